// ===== hw/rtl/tltc_pkg.sv =====
// ----------------------------------------------------------------------------
// tltc_pkg
// Shared types and constants of the two-lane traffic cell update block.
// ----------------------------------------------------------------------------
package tltc_pkg;

  // Stream and configuration widths.
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 88;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 1;

  // Field widths.
  localparam int POS_FIELD_W  = 9;
  localparam int SPEED_W      = 9;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int FLUX_W       = 32;
  localparam int MAX_SPEED_W  = 11;
  localparam int RING_LEN_W   = 10;
  localparam int CELL_WORD_W  = KIND_W + SPEED_W;

  localparam logic [SPEED_W-1:0] SPEED_CAP = 9'd511;
  localparam logic [FLUX_W-1:0]  FLUX_MAX  = 32'hFFFF_FFFF;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEED   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RING_LENGTH = 1'b1;

  localparam logic [MAX_SPEED_W-1:0] MAX_SPEED_RST   = 11'd1;
  localparam logic [RING_LEN_W-1:0]  RING_LENGTH_RST = 10'd500;

  // Request types carried in tuser.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  // Vehicle kinds.
  localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CAR       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_AMBULANCE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED    = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_LOADED  = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_MOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_CHANGED = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_STAY    = 3'd4;

endpackage

// ===== hw/rtl/two_lane_traffic_cell_update_top.sv =====
// ----------------------------------------------------------------------------
// two_lane_traffic_cell_update_top
// Two-lane ring-road cellular automaton: loads cells and updates one vehicle
// per item through a small sequencer around a single add/compare unit.
// ----------------------------------------------------------------------------
// Flow: a load or an update of an out-of-range cell is answered straight from idle,
// an update of an empty cell after a read of its own cell; a vehicle update scans cell
// by cell to the leader, then runs the minimum, move and wrap steps, plus the lane-change steps of an ambulance.
// Throughput: one item at a time; s_tready is low until the result beat is taken.
// Reset (rst, synchronous) starts a clearing pass over all RING_CELLS * LANE_COUNT
// cells (1024 by default) of the cell store before the first beat.
module two_lane_traffic_cell_update_top
  import tltc_pkg::*;
#(
  parameter int RING_CELLS = 512,
  parameter int LANE_COUNT = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  // Slave side. tdata: position[8:0], lane[9], kind[11:10], count_flux[12].
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // tuser: req_type[0].
  input  logic                   s_tuser,
  // Master side. tdata: status[2:0], new_position[11:3], new_lane[12],
  // new_speed[21:13], wrapped[22], car_flux[54:23], ambulance_flux[86:55].
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int POS_W  = (RING_CELLS > 2) ? $clog2(RING_CELLS) : 1;
  localparam int RING_W = POS_W + 1;
  localparam int LANE_W = $clog2(LANE_COUNT);
  localparam int DEPTH  = RING_CELLS * LANE_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int UW     = (RING_W > 11) ? RING_W + 1 : 12;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SELF  = 4'd2;
  localparam logic [3:0] ST_SCAN  = 4'd3;
  localparam logic [3:0] ST_MIN_A = 4'd4;
  localparam logic [3:0] ST_MIN_B = 4'd5;
  localparam logic [3:0] ST_MIN_C = 4'd6;
  localparam logic [3:0] ST_MOVE  = 4'd7;
  localparam logic [3:0] ST_WRAP  = 4'd8;
  localparam logic [3:0] ST_OL_A  = 4'd9;
  localparam logic [3:0] ST_OL_B  = 4'd10;
  localparam logic [3:0] ST_OL_C  = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [LANE_W-1:0] ln,
                                                  input logic [POS_W-1:0] ps);
    cell_addr = ADDR_W'(int'(ln) * RING_CELLS + int'(ps));
  endfunction

  // Configuration registers.
  logic [MAX_SPEED_W-1:0] max_speed;
  logic [RING_LEN_W-1:0]  ring_length;

  // Sequencer and per-item registers.
  logic [3:0]         state, state_next;
  logic [ADDR_W-1:0]  clr_addr;
  logic [POS_W-1:0]   pos_r;
  logic [LANE_W-1:0]  lane_r;
  logic               cnt_r;
  logic [KIND_W-1:0]  me_kind;
  logic [SPEED_W-1:0] my_speed;
  logic [POS_W-1:0]   scan_p;
  logic [POS_W-1:0]   scan_i;
  logic [POS_W-1:0]   gap;
  logic [SPEED_W-1:0] lead_spd;
  logic [UW-1:0]      v_acc;
  logic [UW-1:0]      j_r;
  logic               jwrap_r;

  // Result registers.
  logic [STATUS_W-1:0]    o_status;
  logic [POS_FIELD_W-1:0] o_pos;
  logic                   o_lane;
  logic [SPEED_W-1:0]     o_speed;
  logic                   o_wrap;
  logic [FLUX_W-1:0]      car_flux;
  logic [FLUX_W-1:0]      amb_flux;

  // Cell store: {kind, speed} per cell.
  logic [CELL_WORD_W-1:0] mem [DEPTH];
  logic [CELL_WORD_W-1:0] rd_data;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [CELL_WORD_W-1:0] wr_data;
  logic [KIND_W-1:0]      rd_kind;
  logic [SPEED_W-1:0]     rd_spd;

  // Input fields.
  logic                   in_req;
  logic [POS_FIELD_W-1:0] in_pos;
  logic                   in_lane;
  logic [KIND_W-1:0]      in_kind;
  logic                   in_cnt;
  logic                   in_fire;
  logic                   in_range;

  // Derived values.
  logic [RING_W-1:0]  ring_use;
  logic [RING_W-1:0]  ring_m1;
  logic [POS_W-1:0]   scan_np;
  logic [RING_W-1:0]  scan_inc;
  logic [LANE_W-1:0]  other_lane;
  logic [SPEED_W-1:0] spd_inc;
  logic               v_zero;
  logic               gap_small;

  // Shared add/compare unit.
  logic [UW-1:0] alu_a, alu_b;
  logic          alu_sub;
  logic [UW:0]   alu_sum;
  logic          alu_carry;
  logic          alu_lt;
  logic [UW-1:0] alu_res;
  logic [UW-1:0] alu_min;

  assign in_req  = s_tuser;
  assign in_pos  = s_tdata[8:0];
  assign in_lane = s_tdata[9];
  assign in_kind = s_tdata[11:10];
  assign in_cnt  = s_tdata[12];

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign in_fire  = s_tvalid && s_tready;

  assign m_tdata = {1'b0, amb_flux, car_flux, o_wrap, o_speed, o_lane, o_pos, o_status};

  always_comb begin
    if (int'(ring_length) < 2) begin
      ring_use = RING_W'(2);
    end else if (int'(ring_length) > RING_CELLS) begin
      ring_use = RING_W'(RING_CELLS);
    end else begin
      ring_use = RING_W'(ring_length);
    end
  end

  assign ring_m1  = ring_use - RING_W'(1);
  assign in_range = (int'(in_pos) < int'(ring_use)) && (int'(in_lane) < LANE_COUNT);

  assign scan_inc = RING_W'(scan_p) + RING_W'(1);
  assign scan_np  = (scan_inc >= ring_use) ? '0 : POS_W'(scan_inc);

  assign other_lane = (int'(lane_r) == LANE_COUNT - 1) ? '0 : lane_r + LANE_W'(1);
  assign spd_inc    = (my_speed == SPEED_CAP) ? SPEED_CAP : my_speed + SPEED_W'(1);
  assign v_zero     = (v_acc == '0);
  assign gap_small  = (int'(gap) <= 1);

  assign rd_kind = rd_data[CELL_WORD_W-1:SPEED_W];
  assign rd_spd  = rd_data[SPEED_W-1:0];

  // Operand selection for the shared unit.
  always_comb begin
    alu_a   = v_acc;
    alu_b   = UW'(spd_inc);
    alu_sub = 1'b1;
    unique case (state)
      ST_MIN_A: begin
        alu_a = UW'(max_speed);
        alu_b = UW'(gap);
      end
      ST_MIN_C: begin
        alu_b = UW'(lead_spd);
      end
      ST_MOVE: begin
        alu_a   = UW'(pos_r);
        alu_b   = v_zero ? UW'(1) : v_acc;
        alu_sub = 1'b0;
      end
      ST_WRAP: begin
        alu_a = j_r;
        alu_b = UW'(ring_use);
      end
      default: begin
      end
    endcase
  end

  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (UW+1)'(alu_sub);
  assign alu_carry = alu_sum[UW];
  assign alu_res   = alu_sum[UW-1:0];
  assign alu_lt    = alu_sub && !alu_carry;
  assign alu_min   = alu_lt ? alu_a : alu_b;

  // Sequencer: next state and the memory ports.
  always_comb begin
    state_next = state;
    rd_addr    = cell_addr(LANE_W'(in_lane), POS_W'(in_pos));
    wr_en      = 1'b0;
    wr_addr    = cell_addr(lane_r, pos_r);
    wr_data    = '0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        if (int'(clr_addr) == DEPTH - 1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req == REQ_LOAD) begin
            wr_en      = in_range;
            wr_addr    = cell_addr(LANE_W'(in_lane), POS_W'(in_pos));
            wr_data    = {(in_kind == KIND_UNUSED) ? KIND_EMPTY : in_kind, SPEED_W'(0)};
            state_next = ST_OUT;
          end else if (!in_range) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_SELF;
          end
        end
      end
      ST_SELF: begin
        rd_addr = cell_addr(lane_r, scan_np);
        if (rd_kind == KIND_EMPTY) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr = cell_addr(lane_r, scan_np);
        if (rd_kind != KIND_EMPTY || RING_W'(scan_i) == ring_m1) begin
          state_next = ST_MIN_A;
        end
      end
      ST_MIN_A: state_next = ST_MIN_B;
      ST_MIN_B: state_next = ST_MIN_C;
      ST_MIN_C: state_next = ST_MOVE;
      ST_MOVE: begin
        wr_en   = 1'b1;
        wr_data = v_zero ? {me_kind, SPEED_W'(0)} : '0;
        if (v_zero && me_kind != KIND_AMBULANCE) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_WRAP;
        end
      end
      ST_WRAP: begin
        rd_addr = cell_addr(other_lane, pos_r);
        if (!v_zero) begin
          wr_en      = 1'b1;
          wr_addr    = cell_addr(lane_r, POS_W'(alu_carry ? alu_res : j_r));
          wr_data    = {me_kind, SPEED_W'(v_acc)};
          state_next = ST_OUT;
        end else begin
          state_next = ST_OL_A;
        end
      end
      ST_OL_A: begin
        rd_addr = cell_addr(other_lane, POS_W'(j_r));
        if (rd_kind != KIND_EMPTY) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_OL_B;
        end
      end
      ST_OL_B: begin
        if (rd_kind != KIND_EMPTY) begin
          state_next = ST_OUT;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = cell_addr(other_lane, POS_W'(j_r));
          wr_data    = {KIND_AMBULANCE, SPEED_W'(1)};
          state_next = ST_OL_C;
        end
      end
      ST_OL_C: begin
        wr_en      = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      max_speed   <= MAX_SPEED_RST;
      ring_length <= RING_LENGTH_RST;
      car_flux    <= '0;
      amb_flux    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_SPEED:   max_speed   <= cfg_data;
          REG_RING_LENGTH: ring_length <= cfg_data[RING_LEN_W-1:0];
          default: begin
          end
        endcase
      end
      // A crossing of the ring end counts once per item whose count_flux bit is set, by vehicle kind.
      if (cnt_r && ((state == ST_WRAP && !v_zero && alu_carry) ||
                    (state == ST_OL_B && rd_kind == KIND_EMPTY && jwrap_r))) begin
        if (me_kind == KIND_CAR && car_flux != FLUX_MAX) begin
          car_flux <= car_flux + FLUX_W'(1);
        end
        if (me_kind == KIND_AMBULANCE && amb_flux != FLUX_MAX) begin
          amb_flux <= amb_flux + FLUX_W'(1);
        end
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        pos_r    <= POS_W'(in_pos);
        lane_r   <= LANE_W'(in_lane);
        cnt_r    <= in_cnt;
        scan_p   <= POS_W'(in_pos);
        o_pos    <= in_pos;
        o_lane   <= in_lane;
        o_speed  <= '0;
        o_wrap   <= 1'b0;
        o_status <= (in_req == REQ_LOAD) ? STATUS_LOADED : STATUS_EMPTY;
      end
      ST_SELF: begin
        me_kind  <= rd_kind;
        my_speed <= rd_spd;
        scan_i   <= POS_W'(1);
        gap      <= '0;
        scan_p   <= scan_np;
      end
      ST_SCAN: begin
        if (rd_kind != KIND_EMPTY) begin
          lead_spd <= rd_spd;
        end else begin
          gap <= scan_i;
          if (RING_W'(scan_i) == ring_m1) begin
            // Alone in the lane: the vehicle leads itself.
            lead_spd <= my_speed;
          end else begin
            scan_i <= scan_i + POS_W'(1);
            scan_p <= scan_np;
          end
        end
      end
      ST_MIN_A: v_acc <= alu_min;
      ST_MIN_B: v_acc <= alu_min;
      ST_MIN_C: begin
        if (gap_small) begin
          v_acc <= alu_min;
        end
      end
      ST_MOVE: begin
        j_r      <= alu_res;
        o_status <= STATUS_STAY;
      end
      ST_WRAP: begin
        j_r     <= alu_carry ? alu_res : j_r;
        jwrap_r <= alu_carry;
        if (!v_zero) begin
          o_status <= STATUS_MOVED;
          o_pos    <= POS_FIELD_W'(alu_carry ? alu_res : j_r);
          o_speed  <= SPEED_W'(v_acc);
          o_wrap   <= alu_carry;
        end
      end
      ST_OL_B: begin
        if (rd_kind == KIND_EMPTY) begin
          o_status <= STATUS_CHANGED;
          o_pos    <= POS_FIELD_W'(j_r);
          o_lane   <= 1'(other_lane);
          o_speed  <= SPEED_W'(1);
          o_wrap   <= jwrap_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/tltc_checker.sv =====
// ----------------------------------------------------------------------------
// tltc_checker
// Port-level checks of the two-lane traffic cell update block.
// ----------------------------------------------------------------------------
module tltc_checker
  import tltc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [M_TDATA_W-1:0]   m_tdata
);

  // Reset starts the clearing pass: nothing is offered or taken.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("beat offered or taken right after reset");

  // One item at a time: no new beat is taken while a result waits.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // Exactly one result per item: the result beat drops after it is taken.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> !m_tvalid)
    else $error("result repeated");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[STATUS_W-1:0] <= STATUS_STAY)
    else $error("status code out of range");

endmodule

bind two_lane_traffic_cell_update_top tltc_checker u_tltc_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);
